// ===== hw/rtl/rra_pkg.sv =====
package rra_pkg;

    // Table geometry
    localparam int NUM_REGS  = 64;
    localparam int TAG_BITS  = 32;
    localparam int LOCK_BITS = 8;
    localparam int MASK_BITS = 64;
    localparam int IDX_BITS  = $clog2(NUM_REGS);
    localparam int CNT_BITS  = $clog2(NUM_REGS + 1);

    localparam logic [LOCK_BITS-1:0] LOCK_MAX = '1;
    localparam logic [LOCK_BITS-1:0] LOCK_ONE = LOCK_BITS'(1);

    // Command codes
    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESERVE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CAN_SAVE = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_MISS,
        S_SPILL,
        S_REL,
        S_RESP
    } state_t;

endpackage

// ===== hw/rtl/round_robin_register_allocator.sv =====
// Round-robin register allocator.
// Request channel (req_valid / req_stall) carries one command per transaction:
// acquire a register for value_tag, or release the lock on release_index.
// Response channel (rsp_valid / rsp_stall) returns exactly one transaction per
// request: granted register, hit / fill / spill / newly-saved / exhausted flags.
// preserve_mask and can_save_mask are written through cfg_write_en / cfg_index /
// cfg_data; the user must write them only while no request is in flight, and the
// block does not enforce it. Flow: one request is worked on at a time. A
// release passes through S_REL and S_RESP before its response is loaded. An
// acquire scans the tag memory one entry a cycle through a single read port while
// the same step counter walks the round-robin candidate bits from the rover: a hit
// goes on through S_HIT, a miss finishes the full scan, then takes the decision in
// S_MISS and, with a spill, the spill tag read into S_SPILL. The single-port tag
// scan sets the acquire time. Requests are not overlapped: the next request is
// taken in S_IDLE, after the current response is in the output register.
// The response sits in an output register; a new request is taken while it
// waits under rsp_stall, but the next response is held back until it is taken.
// Reset clears all entry valid bits, locked, dirty and saved bits, the rover and
// both masks (the lock count memory itself is not cleared); it takes effect at once.
module round_robin_register_allocator
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,

    input  logic        req_valid,
    output logic        req_stall,
    input  logic        command,
    input  logic [31:0] value_tag,
    input  logic [1:0]  access_kind,
    input  logic [5:0]  release_index,

    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [5:0]  granted_index,
    output logic        was_hit,
    output logic        fill_needed,
    output logic        spill_needed,
    output logic [31:0] spill_tag,
    output logic        newly_saved,
    output logic        no_register
);

    localparam int NR = rra_pkg::NUM_REGS;
    localparam int IB = rra_pkg::IDX_BITS;
    localparam int CB = rra_pkg::CNT_BITS;
    localparam int TB = rra_pkg::TAG_BITS;
    localparam int LB = rra_pkg::LOCK_BITS;
    localparam int MB = rra_pkg::MASK_BITS;

    rra_pkg::state_t state_reg, state_next;

    // Configuration and allocation state
    logic [MB-1:0]  preserve_reg;
    logic [MB-1:0]  can_save_reg;
    logic [NR-1:0]  valid_reg;
    logic [NR-1:0]  nz_reg;
    logic [NR-1:0]  dirty_reg;
    logic [NR-1:0]  saved_reg;
    logic [IB-1:0]  rover_reg;

    // Request capture
    logic           cmd_reg;
    logic [TB-1:0]  tag_reg;
    logic           dirty_in_reg;
    logic [5:0]     rel_reg;

    // Scan sequencer
    logic [CB-1:0]  cnt_reg;
    logic           found1_reg;
    logic [IB-1:0]  k1_reg;
    logic           found2_reg;
    logic [IB-1:0]  k2_reg;
    logic [IB-1:0]  hit_idx_reg;

    // Memories
    logic [TB-1:0]  entry_tag_mem [NR];
    logic [LB-1:0]  lock_mem [NR];
    logic [TB-1:0]  tag_rd_reg;
    logic [LB-1:0]  lock_rd_reg;

    // Pending result
    logic [5:0]     res_index_reg;
    logic           res_hit_reg;
    logic           res_fill_reg;
    logic           res_spill_reg;
    logic [31:0]    res_spill_tag_reg;
    logic           res_saved_reg;
    logic           res_none_reg;

    // Output register
    logic           rsp_valid_reg;
    logic [5:0]     granted_index_reg;
    logic           was_hit_reg;
    logic           fill_needed_reg;
    logic           spill_needed_reg;
    logic [31:0]    spill_tag_reg;
    logic           newly_saved_reg;
    logic           no_register_reg;

    // Control from the output decoder
    logic           req_take;
    logic           rsp_free;
    logic [IB-1:0]  tag_rd_addr;
    logic [IB-1:0]  lock_rd_addr;
    logic           lock_we;
    logic [IB-1:0]  lock_wa;
    logic [LB-1:0]  lock_wd;
    logic           install_we;
    logic [IB-1:0]  install_idx;
    logic           install_new_save;

    // Shared step unit: entry index, compare index and rotated candidate index
    logic           scan_issue;
    logic [IB-1:0]  scan_idx;
    logic [CB-1:0]  cmp_full;
    logic [IB-1:0]  cmp_idx;
    logic [IB:0]    rr_sum;
    logic [IB:0]    rr_wrap;
    logic [IB-1:0]  rr_idx;
    logic           cand1;
    logic           cand2;
    logic           hit_now;
    logic [LB-1:0]  rel_lock;
    logic           rel_in_range;
    logic [IB-1:0]  rel_idx;
    logic [IB-1:0]  rover_next;

    assign scan_issue = (cnt_reg < CB'(NR));
    assign scan_idx   = cnt_reg[IB-1:0];
    assign cmp_full   = cnt_reg - CB'(1);
    assign cmp_idx    = cmp_full[IB-1:0];
    assign rr_sum     = {1'b0, rover_reg} + {1'b0, scan_idx};
    assign rr_wrap    = (rr_sum >= (IB+1)'(NR)) ? (rr_sum - (IB+1)'(NR)) : rr_sum;
    assign rr_idx     = rr_wrap[IB-1:0];
    assign cand1      = preserve_reg[rr_idx] & saved_reg[rr_idx] & ~nz_reg[rr_idx];
    assign cand2      = preserve_reg[rr_idx] & can_save_reg[rr_idx];
    assign hit_now    = (state_reg == rra_pkg::S_SCAN) && (cnt_reg != '0)
                        && valid_reg[cmp_idx] && (tag_rd_reg == tag_reg);

    assign rel_idx      = rel_reg[IB-1:0];
    assign rel_in_range = ({1'b0, rel_reg} < 7'(NR));
    assign rel_lock     = valid_reg[rel_idx] ? lock_rd_reg : '0;
    assign rover_next   = (install_idx == IB'(NR - 1)) ? '0 : (install_idx + IB'(1));

    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign req_take = req_valid && !req_stall;

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rra_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rra_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (command == rra_pkg::CMD_RELEASE) ? rra_pkg::S_REL
                                                                  : rra_pkg::S_SCAN;
                end
            end
            rra_pkg::S_SCAN:
            begin
                if (hit_now)
                begin
                    state_next = rra_pkg::S_HIT;
                end
                else if (!scan_issue)
                begin
                    state_next = rra_pkg::S_MISS;
                end
            end
            rra_pkg::S_HIT:   state_next = rra_pkg::S_RESP;
            rra_pkg::S_REL:   state_next = rra_pkg::S_RESP;
            rra_pkg::S_MISS:  state_next = found1_reg ? rra_pkg::S_SPILL : rra_pkg::S_RESP;
            rra_pkg::S_SPILL: state_next = rra_pkg::S_RESP;
            rra_pkg::S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = rra_pkg::S_IDLE;
                end
            end
            default:          state_next = rra_pkg::S_IDLE;
        endcase
    end

    // Memory and update controls
    always_comb
    begin
        req_stall        = 1'b1;
        tag_rd_addr      = scan_idx;
        lock_rd_addr     = cmp_idx;
        lock_we          = 1'b0;
        lock_wa          = hit_idx_reg;
        lock_wd          = rra_pkg::LOCK_ONE;
        install_we       = 1'b0;
        install_idx      = k1_reg;
        install_new_save = 1'b0;
        unique case (state_reg)
            rra_pkg::S_IDLE:
            begin
                req_stall    = 1'b0;
                lock_rd_addr = release_index[IB-1:0];
            end
            rra_pkg::S_SCAN:
            begin
                tag_rd_addr  = scan_idx;
                lock_rd_addr = cmp_idx;
            end
            rra_pkg::S_HIT:
            begin
                lock_we = 1'b1;
                lock_wa = hit_idx_reg;
                lock_wd = (lock_rd_reg == rra_pkg::LOCK_MAX) ? lock_rd_reg
                                                            : (lock_rd_reg + LB'(1));
            end
            rra_pkg::S_REL:
            begin
                lock_we = rel_in_range && (rel_lock != '0);
                lock_wa = rel_idx;
                lock_wd = rel_lock - LB'(1);
            end
            rra_pkg::S_MISS:
            begin
                tag_rd_addr = k1_reg;
                if (!found1_reg && found2_reg)
                begin
                    install_we       = 1'b1;
                    install_idx      = k2_reg;
                    install_new_save = 1'b1;
                    lock_we          = 1'b1;
                    lock_wa          = k2_reg;
                    lock_wd          = rra_pkg::LOCK_ONE;
                end
            end
            rra_pkg::S_SPILL:
            begin
                install_we  = 1'b1;
                install_idx = k1_reg;
                lock_we     = 1'b1;
                lock_wa     = k1_reg;
                lock_wd     = rra_pkg::LOCK_ONE;
            end
            rra_pkg::S_RESP:
            begin
                req_stall = 1'b1;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // Tag memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (install_we)
        begin
            entry_tag_mem[install_idx] <= tag_reg;
        end
        tag_rd_reg <= entry_tag_mem[tag_rd_addr];
    end

    // Lock count memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (lock_we)
        begin
            lock_mem[lock_wa] <= lock_wd;
        end
        lock_rd_reg <= lock_mem[lock_rd_addr];
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preserve_reg <= '0;
            can_save_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                rra_pkg::CFG_PRESERVE: preserve_reg <= cfg_data;
                rra_pkg::CFG_CAN_SAVE: can_save_reg <= cfg_data;
                default:               preserve_reg <= preserve_reg;
            endcase
        end
    end

    // Allocation state: valid, locked, dirty, saved bits and rover
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            nz_reg    <= '0;
            dirty_reg <= '0;
            saved_reg <= '0;
            rover_reg <= '0;
        end
        else
        begin
            if (state_reg == rra_pkg::S_HIT)
            begin
                nz_reg[hit_idx_reg] <= 1'b1;
                if (dirty_in_reg)
                begin
                    dirty_reg[hit_idx_reg] <= 1'b1;
                end
            end
            if ((state_reg == rra_pkg::S_REL) && lock_we && (lock_wd == '0))
            begin
                nz_reg[rel_idx] <= 1'b0;
            end
            if (install_we)
            begin
                valid_reg[install_idx] <= 1'b1;
                nz_reg[install_idx]    <= 1'b1;
                dirty_reg[install_idx] <= dirty_in_reg;
                rover_reg              <= rover_next;
                if (install_new_save)
                begin
                    saved_reg[install_idx] <= 1'b1;
                end
            end
        end
    end

    // Scan counter and first-candidate capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            found1_reg <= 1'b0;
            found2_reg <= 1'b0;
        end
        else if (req_take)
        begin
            cnt_reg    <= '0;
            found1_reg <= 1'b0;
            found2_reg <= 1'b0;
        end
        else if ((state_reg == rra_pkg::S_SCAN) && scan_issue)
        begin
            cnt_reg <= cnt_reg + CB'(1);
            if (cand1 && !found1_reg)
            begin
                found1_reg <= 1'b1;
            end
            if (cand2 && !found2_reg)
            begin
                found2_reg <= 1'b1;
            end
        end
    end

    // Candidate indexes, hit index and request capture
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cmd_reg      <= command;
            tag_reg      <= value_tag;
            dirty_in_reg <= access_kind[1];
            rel_reg      <= release_index;
        end
        if ((state_reg == rra_pkg::S_SCAN) && scan_issue)
        begin
            if (cand1 && !found1_reg)
            begin
                k1_reg <= rr_idx;
            end
            if (cand2 && !found2_reg)
            begin
                k2_reg <= rr_idx;
            end
        end
        if (hit_now)
        begin
            hit_idx_reg <= cmp_idx;
        end
    end

    // Build the pending result
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rra_pkg::S_HIT:
            begin
                res_index_reg     <= 6'(hit_idx_reg);
                res_hit_reg       <= 1'b1;
                res_fill_reg      <= 1'b0;
                res_spill_reg     <= 1'b0;
                res_spill_tag_reg <= '0;
                res_saved_reg     <= 1'b0;
                res_none_reg      <= 1'b0;
            end
            rra_pkg::S_REL:
            begin
                res_index_reg     <= rel_reg;
                res_hit_reg       <= 1'b0;
                res_fill_reg      <= 1'b0;
                res_spill_reg     <= 1'b0;
                res_spill_tag_reg <= '0;
                res_saved_reg     <= 1'b0;
                res_none_reg      <= 1'b0;
            end
            rra_pkg::S_MISS:
            begin
                res_index_reg     <= found2_reg ? 6'(k2_reg) : '0;
                res_hit_reg       <= 1'b0;
                res_fill_reg      <= found2_reg;
                res_spill_reg     <= 1'b0;
                res_spill_tag_reg <= '0;
                res_saved_reg     <= found2_reg;
                res_none_reg      <= !found2_reg;
            end
            rra_pkg::S_SPILL:
            begin
                res_index_reg     <= 6'(k1_reg);
                res_hit_reg       <= 1'b0;
                res_fill_reg      <= 1'b1;
                res_spill_reg     <= dirty_reg[k1_reg];
                res_spill_tag_reg <= dirty_reg[k1_reg] ? 32'(tag_rd_reg) : '0;
                res_saved_reg     <= 1'b0;
                res_none_reg      <= 1'b0;
            end
            default:
            begin
                res_index_reg <= res_index_reg;
            end
        endcase
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((state_reg == rra_pkg::S_RESP) && rsp_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Load the output payload once the previous transaction is gone
    always_ff @(posedge clk)
    begin
        if ((state_reg == rra_pkg::S_RESP) && rsp_free)
        begin
            granted_index_reg <= res_index_reg;
            was_hit_reg       <= res_hit_reg;
            fill_needed_reg   <= res_fill_reg;
            spill_needed_reg  <= res_spill_reg;
            spill_tag_reg     <= res_spill_tag_reg;
            newly_saved_reg   <= res_saved_reg;
            no_register_reg   <= res_none_reg;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign granted_index = granted_index_reg;
    assign was_hit       = was_hit_reg;
    assign fill_needed   = fill_needed_reg;
    assign spill_needed  = spill_needed_reg;
    assign spill_tag     = spill_tag_reg;
    assign newly_saved   = newly_saved_reg;
    assign no_register   = no_register_reg;

    // A locked or dirty register always holds an installed entry
    assert property (@(posedge clk) disable iff (!rst_n)
        ((nz_reg | dirty_reg) & ~valid_reg) == '0)
        else $error("lock or dirty bit set on an invalid entry");

    // A spill only comes with a fill through the saved search
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && spill_needed) |-> (fill_needed && !newly_saved && !was_hit))
        else $error("spill flagged outside the saved-register path");

    // The rover moves only when a register is installed
    assert property (@(posedge clk) disable iff (!rst_n)
        (rover_reg != $past(rover_reg)) |->
            ($past(state_reg) == rra_pkg::S_MISS || $past(state_reg) == rra_pkg::S_SPILL))
        else $error("rover moved without an install");

    // A release never reaches the tag scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rra_pkg::S_SCAN) |-> (cmd_reg == rra_pkg::CMD_ACQUIRE))
        else $error("release command entered the tag scan");

endmodule
